### src/cdad_pkg.sv
// ----------------------------------------------------------------------------
// cdad_pkg: shared types and constants for the date-plus-days block
// Field widths, status codes, microcode encoding, the control program and
// the month length lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package cdad_pkg;

    // Field widths
    localparam int YEAR_IN_W = 14;
    localparam int MONTH_W   = 4;
    localparam int DAY_IN_W  = 5;
    localparam int OFF_IN_W  = 17;
    localparam int STATUS_W  = 2;

    // Working widths: year may run past the field and to -1, day spans the offset
    localparam int YEAR_W    = 16;
    localparam int DAY_W     = 18;
    localparam int LEN_W     = 5;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_DATE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;

    // Months
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    // Leap rule constants, on the year taken mod 400
    localparam logic [YEAR_IN_W-1:0] CYCLE_400 = 14'd400;
    localparam logic [YEAR_IN_W-1:0] CYCLE_TOP = 14'd399;
    localparam logic [YEAR_IN_W-1:0] CENT_1    = 14'd100;
    localparam logic [YEAR_IN_W-1:0] CENT_2    = 14'd200;
    localparam logic [YEAR_IN_W-1:0] CENT_3    = 14'd300;
    localparam logic [LEN_W-1:0]     FEB_LEAP  = 5'd29;

    localparam logic [LEN_W-1:0] MONTH_LEN_TAB [0:12] = '{
        5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // Microcode encoding
    localparam int STEP_W = 4;
    localparam int COND_W = 4;
    localparam int OP_W   = 4;

    typedef logic [STEP_W-1:0] cdad_step_t;
    typedef logic [COND_W-1:0] cdad_cond_code_t;
    typedef logic [OP_W-1:0]   cdad_op_t;

    // Program steps
    localparam cdad_step_t STEP_WAIT  = 4'd0;
    localparam cdad_step_t STEP_MOD   = 4'd1;
    localparam cdad_step_t STEP_CHECK = 4'd2;
    localparam cdad_step_t STEP_DIR   = 4'd3;
    localparam cdad_step_t STEP_FWD   = 4'd4;
    localparam cdad_step_t STEP_BACK  = 4'd5;
    localparam cdad_step_t STEP_BACK2 = 4'd6;
    localparam cdad_step_t STEP_FIN   = 4'd7;
    localparam cdad_step_t STEP_OUT   = 4'd8;
    localparam int         NUM_STEPS  = 9;

    // Condition selects
    localparam cdad_cond_code_t C_IN_VALID  = 4'd0;
    localparam cdad_cond_code_t C_MOD_BIG   = 4'd1;
    localparam cdad_cond_code_t C_DATE_BAD  = 4'd2;
    localparam cdad_cond_code_t C_OFF_NEG   = 4'd3;
    localparam cdad_cond_code_t C_DAY_OVER  = 4'd4;
    localparam cdad_cond_code_t C_DAY_POS   = 4'd5;
    localparam cdad_cond_code_t C_YEAR_NEG  = 4'd6;
    localparam cdad_cond_code_t C_RANGE_BAD = 4'd7;
    localparam cdad_cond_code_t C_OUT_FREE  = 4'd8;

    // Datapath operations
    localparam cdad_op_t OP_NOP          = 4'd0;
    localparam cdad_op_t OP_LOAD         = 4'd1;
    localparam cdad_op_t OP_MOD_SUB      = 4'd2;
    localparam cdad_op_t OP_SET_BAD      = 4'd3;
    localparam cdad_op_t OP_ADD_OFF      = 4'd4;
    localparam cdad_op_t OP_CARRY        = 4'd5;
    localparam cdad_op_t OP_BORROW_MONTH = 4'd6;
    localparam cdad_op_t OP_BORROW_DAY   = 4'd7;
    localparam cdad_op_t OP_SET_RANGE    = 4'd8;
    localparam cdad_op_t OP_EMIT         = 4'd9;

    // One control word: condition, then op and next step for each outcome
    typedef struct packed {
        cdad_cond_code_t cond;
        cdad_op_t        op_hit;
        cdad_step_t      nxt_hit;
        cdad_op_t        op_miss;
        cdad_step_t      nxt_miss;
    } cdad_uword_t;

    // Condition flags from the datapath
    typedef struct packed {
        logic in_valid;
        logic mod_big;
        logic date_bad;
        logic off_neg;
        logic day_over;
        logic day_pos;
        logic year_neg;
        logic range_bad;
        logic out_free;
    } cdad_cond_t;

    // Control from the sequencer
    typedef struct packed {
        cdad_op_t op;
        logic     idle;
    } cdad_ctrl_t;

    // Control program
    localparam cdad_uword_t UCODE [0:NUM_STEPS-1] = '{
        '{C_IN_VALID,  OP_LOAD,      STEP_MOD,  OP_NOP,          STEP_WAIT},
        '{C_MOD_BIG,   OP_MOD_SUB,   STEP_MOD,  OP_NOP,          STEP_CHECK},
        '{C_DATE_BAD,  OP_SET_BAD,   STEP_OUT,  OP_ADD_OFF,      STEP_DIR},
        '{C_OFF_NEG,   OP_NOP,       STEP_BACK, OP_NOP,          STEP_FWD},
        '{C_DAY_OVER,  OP_CARRY,     STEP_FWD,  OP_NOP,          STEP_FIN},
        '{C_DAY_POS,   OP_NOP,       STEP_FIN,  OP_BORROW_MONTH, STEP_BACK2},
        '{C_YEAR_NEG,  OP_NOP,       STEP_FIN,  OP_BORROW_DAY,   STEP_BACK},
        '{C_RANGE_BAD, OP_SET_RANGE, STEP_OUT,  OP_NOP,          STEP_OUT},
        '{C_OUT_FREE,  OP_EMIT,      STEP_WAIT, OP_NOP,          STEP_OUT}
    };

    // Month length; month outside 1..12 gives zero
    function automatic logic [LEN_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                  input logic leap);
        logic [LEN_W-1:0] len;
        len = '0;
        if (month == MONTH_FEB && leap)
            len = FEB_LEAP;
        else if (month <= MONTH_DEC)
            len = MONTH_LEN_TAB[month];
        return len;
    endfunction

endpackage

`default_nettype wire

### src/cdad_if.sv
// ----------------------------------------------------------------------------
// cdad_in_if / cdad_out_if: valid-ready channels of the date-plus-days block
// A transaction moves at a rising edge where valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface cdad_in_if;
    import cdad_pkg::*;

    logic                        valid;
    logic                        ready;
    logic [YEAR_IN_W-1:0]        start_year;
    logic [MONTH_W-1:0]          start_month;
    logic [DAY_IN_W-1:0]         start_day;
    logic signed [OFF_IN_W-1:0]  offset_days;

    modport source (output valid, start_year, start_month, start_day, offset_days,
                    input ready);
    modport sink   (input valid, start_year, start_month, start_day, offset_days,
                    output ready);
endinterface

interface cdad_out_if;
    import cdad_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [YEAR_IN_W-1:0] result_year;
    logic [MONTH_W-1:0]   result_month;
    logic [DAY_IN_W-1:0]  result_day;
    logic [STATUS_W-1:0]  status;

    modport source (output valid, result_year, result_month, result_day, status,
                    input ready);
    modport sink   (input valid, result_year, result_month, result_day, status,
                    output ready);
endinterface

`default_nettype wire

### src/cdad_seq.sv
// ----------------------------------------------------------------------------
// cdad_seq: microcode sequencer
// Steps through the control program, picks a condition flag per step and
// issues the datapath operation and the next step for its outcome.
// ----------------------------------------------------------------------------
`default_nettype none

module cdad_seq (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cdad_pkg::cdad_cond_t cond,
    output cdad_pkg::cdad_ctrl_t  ctrl
);
    import cdad_pkg::*;

    cdad_step_t  step_reg;
    cdad_step_t  step_next;
    cdad_uword_t uword;
    logic        hit;

    // Fetch the control word
    assign uword = UCODE[step_reg];

    // Select the tested condition
    always_comb
    begin
        unique case (uword.cond)
            C_IN_VALID:  hit = cond.in_valid;
            C_MOD_BIG:   hit = cond.mod_big;
            C_DATE_BAD:  hit = cond.date_bad;
            C_OFF_NEG:   hit = cond.off_neg;
            C_DAY_OVER:  hit = cond.day_over;
            C_DAY_POS:   hit = cond.day_pos;
            C_YEAR_NEG:  hit = cond.year_neg;
            C_RANGE_BAD: hit = cond.range_bad;
            C_OUT_FREE:  hit = cond.out_free;
            default:     hit = 1'b0;
        endcase
    end

    // Issue the operation and branch
    always_comb
    begin
        ctrl.op   = hit ? uword.op_hit : uword.op_miss;
        ctrl.idle = (step_reg == STEP_WAIT);
        step_next = hit ? uword.nxt_hit : uword.nxt_miss;
    end

    // Advance the step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= STEP_WAIT;
        else
            step_reg <= step_next;
    end

endmodule

`default_nettype wire

### src/calendar_date_add_days.sv
// ----------------------------------------------------------------------------
// calendar_date_add_days: Gregorian date plus a signed number of days
// Checks the starting date and walks the offset month by month under a
// microcoded sequencer; returns the resulting date and a status.
// ----------------------------------------------------------------------------
// One transaction in gives one transaction out: status 0 with the resulting
// date, 1 for an illegal starting date, 2 when the result falls before year 0
// or after YEAR_MAX (date fields zero whenever status is nonzero). The offset
// saturates to +/-MAX_OFFSET. The block handles one item at a time. The time
// a legal item takes is set by the mod-400 reduction of the year and the
// month-step loop of the sequencer, which crosses one month per carry step
// going forward, and one month per pair of borrow steps (month, then day)
// going backward. The emit step also waits while the output register still
// holds an unread result. The finished result sits in an output register, so
// the next item is taken while it waits to be read.
`default_nettype none

module calendar_date_add_days #(
    parameter int YEAR_MAX   = 9999,
    parameter int MAX_OFFSET = 65535
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    cdad_in_if.sink    req,
    cdad_out_if.source rsp
);
    import cdad_pkg::*;

    localparam int SAT_W = 21;
    localparam logic signed [SAT_W-1:0] OFF_LIM   = SAT_W'(MAX_OFFSET);
    localparam logic signed [YEAR_W+1:0] YEAR_LIM = (YEAR_W+2)'(YEAR_MAX);

    cdad_cond_t cond;
    cdad_ctrl_t ctrl;

    logic signed [YEAR_W-1:0] year_reg,   year_next;
    logic [MONTH_W-1:0]       month_reg,  month_next;
    logic signed [DAY_W-1:0]  day_reg,    day_next;
    logic signed [DAY_W-1:0]  off_reg,    off_next;
    logic [YEAR_IN_W-1:0]     ymod_reg,   ymod_next;
    logic [STATUS_W-1:0]      status_reg, status_next;

    logic                     out_valid_reg;
    logic [YEAR_IN_W-1:0]     res_year_reg;
    logic [MONTH_W-1:0]       res_month_reg;
    logic [DAY_IN_W-1:0]      res_day_reg;
    logic [STATUS_W-1:0]      res_status_reg;

    logic                     leap;
    logic [LEN_W-1:0]         len;
    logic signed [DAY_W-1:0]  len_s;
    logic signed [SAT_W-1:0]  off_wide;
    logic signed [SAT_W-1:0]  off_sat;
    logic [YEAR_IN_W-1:0]     ymod_inc;
    logic [YEAR_IN_W-1:0]     ymod_dec;

    // Sequencer
    cdad_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .cond  (cond),
        .ctrl  (ctrl)
    );

    // Leap test on the year mod 400, and the current month length
    always_comb
    begin
        leap  = (ymod_reg[1:0] == 2'b00) && (ymod_reg != CENT_1) &&
                (ymod_reg != CENT_2) && (ymod_reg != CENT_3);
        len   = month_len(month_reg, leap);
        len_s = $signed({{(DAY_W-LEN_W){1'b0}}, len});
    end

    // Saturate the incoming offset
    always_comb
    begin
        off_wide = SAT_W'(req.offset_days);
        if (off_wide > OFF_LIM)
            off_sat = OFF_LIM;
        else if (off_wide < -OFF_LIM)
            off_sat = -OFF_LIM;
        else
            off_sat = off_wide;
    end

    // Wrap the mod-400 year counter
    assign ymod_inc = (ymod_reg == CYCLE_TOP) ? '0 : ymod_reg + 1'b1;
    assign ymod_dec = (ymod_reg == '0) ? CYCLE_TOP : ymod_reg - 1'b1;

    // Condition flags
    always_comb
    begin
        cond.in_valid  = req.valid;
        cond.mod_big   = (ymod_reg >= CYCLE_400);
        cond.date_bad  = (month_reg == '0) || (month_reg > MONTH_DEC) ||
                         (day_reg <= 0) || (day_reg > len_s);
        cond.off_neg   = off_reg[DAY_W-1];
        cond.day_over  = (day_reg > len_s);
        cond.day_pos   = (day_reg > 0);
        cond.year_neg  = year_reg[YEAR_W-1];
        cond.range_bad = year_reg[YEAR_W-1] || ((YEAR_W+2)'(year_reg) > YEAR_LIM);
        cond.out_free  = !out_valid_reg || rsp.ready;
    end

    // Datapath operations
    always_comb
    begin
        year_next   = year_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        off_next    = off_reg;
        ymod_next   = ymod_reg;
        status_next = status_reg;
        unique case (ctrl.op)
            OP_LOAD:
            begin
                year_next   = $signed({{(YEAR_W-YEAR_IN_W){1'b0}}, req.start_year});
                month_next  = req.start_month;
                day_next    = $signed({{(DAY_W-DAY_IN_W){1'b0}}, req.start_day});
                off_next    = off_sat[DAY_W-1:0];
                ymod_next   = req.start_year;
                status_next = ST_OK;
            end
            OP_MOD_SUB:
                ymod_next = ymod_reg - CYCLE_400;
            OP_SET_BAD:
                status_next = ST_BAD_DATE;
            OP_ADD_OFF:
                day_next = day_reg + off_reg;
            OP_CARRY:
            begin
                day_next = day_reg - len_s;
                if (month_reg == MONTH_DEC)
                begin
                    month_next = MONTH_JAN;
                    year_next  = year_reg + YEAR_W'(1);
                    ymod_next  = ymod_inc;
                end
                else
                    month_next = month_reg + 1'b1;
            end
            OP_BORROW_MONTH:
            begin
                if (month_reg == MONTH_JAN)
                begin
                    month_next = MONTH_DEC;
                    year_next  = year_reg - YEAR_W'(1);
                    ymod_next  = ymod_dec;
                end
                else
                    month_next = month_reg - 1'b1;
            end
            OP_BORROW_DAY:
                day_next = day_reg + len_s;
            OP_SET_RANGE:
                status_next = ST_RANGE;
            OP_EMIT,
            OP_NOP:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Hold the working registers
    always_ff @(posedge clk)
    begin
        year_reg   <= year_next;
        month_reg  <= month_next;
        day_reg    <= day_next;
        off_reg    <= off_next;
        ymod_reg   <= ymod_next;
        status_reg <= status_next;
    end

    // Output valid: set on emit, drop when the transaction is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctrl.op == OP_EMIT)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    // Capture the result, zero date fields on any error
    always_ff @(posedge clk)
    begin
        if (ctrl.op == OP_EMIT)
        begin
            res_status_reg <= status_reg;
            if (status_reg == ST_OK)
            begin
                res_year_reg  <= year_reg[YEAR_IN_W-1:0];
                res_month_reg <= month_reg;
                res_day_reg   <= day_reg[DAY_IN_W-1:0];
            end
            else
            begin
                res_year_reg  <= '0;
                res_month_reg <= '0;
                res_day_reg   <= '0;
            end
        end
    end

    // Ports
    assign req.ready        = ctrl.idle;
    assign rsp.valid        = out_valid_reg;
    assign rsp.result_year  = res_year_reg;
    assign rsp.result_month = res_month_reg;
    assign rsp.result_day   = res_day_reg;
    assign rsp.status       = res_status_reg;

endmodule

`default_nettype wire

### tb/cdad_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdad_checker: scoreboard for the date-plus-days block
// Watches both channels. Every request transaction that is taken gets a
// predicted result date, and every response transaction is compared field
// by field against the oldest prediction still waiting.
// ----------------------------------------------------------------------------

module cdad_checker #(
    parameter int YEAR_MAX   = 9999,
    parameter int MAX_OFFSET = 65535
) (
    input  wire logic clk,
    input  wire logic rst_n,
    cdad_in_if        req,
    cdad_out_if       rsp,
    output int        mismatches,
    output int        outstanding
);
    import cdad_pkg::*;

    typedef struct packed {
        logic [YEAR_IN_W-1:0] year;
        logic [MONTH_W-1:0]   month;
        logic [DAY_IN_W-1:0]  day;
        logic [STATUS_W-1:0]  status;
    } date_result_t;

    // Predicted results, oldest first
    date_result_t expected_dates[$];

    function automatic logic leap_year(input int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // Caller guarantees y >= 0 and m in 1..12
    function automatic int month_days(input int y, input int m);
        if (m == int'(MONTH_FEB) && leap_year(y))
            return int'(FEB_LEAP);
        return int'(MONTH_LEN_TAB[m]);
    endfunction

    // Walk the offset month by month from the starting date
    function automatic date_result_t add_days(input int y0, input int m0,
                                              input int d0, input int off0);
        int                  y;
        int                  m;
        int                  d;
        int                  off;
        logic [STATUS_W-1:0] st;
        date_result_t        r;
        y   = y0;
        m   = m0;
        d   = d0;
        off = off0;
        if (off > MAX_OFFSET)
            off = MAX_OFFSET;
        if (off < -MAX_OFFSET)
            off = -MAX_OFFSET;
        st = ST_OK;
        if (m < 1 || m > 12 || d < 1 || d > month_days(y, m)) begin
            st = ST_BAD_DATE;
        end
        else if (off >= 0) begin
            d = d + off;
            while (d > month_days(y, m)) begin
                d = d - month_days(y, m);
                m = m + 1;
                if (m == 13) begin
                    m = 1;
                    y = y + 1;
                end
            end
            if (y > YEAR_MAX)
                st = ST_RANGE;
        end
        else begin
            d = d + off;
            // Stop borrowing once the year drops below zero
            while (d <= 0 && y >= 0) begin
                m = m - 1;
                if (m == 0) begin
                    m = 12;
                    y = y - 1;
                end
                if (y >= 0)
                    d = d + month_days(y, m);
            end
            if (y < 0 || y > YEAR_MAX)
                st = ST_RANGE;
        end
        r = '0;
        if (st == ST_OK) begin
            r.year  = YEAR_IN_W'(y);
            r.month = MONTH_W'(m);
            r.day   = DAY_IN_W'(d);
        end
        r.status = st;
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches = mismatches + 1;
        end
    endtask

    // Predict on each request transaction, compare on each response transaction
    always @(posedge clk or negedge rst_n) begin
        date_result_t want;
        int           off;
        if (!rst_n) begin
            mismatches = 0;
            outstanding <= 0;
        end
        else begin
            if (req.valid && req.ready) begin
                off = $signed(req.offset_days);
                expected_dates.push_back(add_days(int'(req.start_year),
                                                  int'(req.start_month),
                                                  int'(req.start_day), off));
            end
            if (rsp.valid && rsp.ready) begin
                if (expected_dates.size() == 0) begin
                    $error("unexpected result transaction: %0d-%0d-%0d status %0d",
                           rsp.result_year, rsp.result_month, rsp.result_day,
                           rsp.status);
                    mismatches = mismatches + 1;
                end
                else begin
                    want = expected_dates.pop_front();
                    check_field("result_year", int'(want.year), int'(rsp.result_year));
                    check_field("result_month", int'(want.month), int'(rsp.result_month));
                    check_field("result_day", int'(want.day), int'(rsp.result_day));
                    check_field("status", int'(want.status), int'(rsp.status));
                end
            end
            outstanding <= expected_dates.size();
        end
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for calendar_date_add_days
// Drives a directed set of calendar corner cases, then random dates and
// offsets, with random gaps on both channels and one long response stall.
// The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------

module tb_top;
    import cdad_pkg::*;

    localparam int YEAR_MAX     = 9999;
    localparam int MAX_OFFSET   = 65535;
    localparam int NUM_RANDOM   = 246;
    localparam int QUIET_LIMIT  = 40000;
    localparam int HOLD_AT      = 40;
    localparam int HOLD_CYCLES  = 5000;
    localparam int DRAIN_CYCLES = 100;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   outstanding;
    int   sent;
    bit   send_calm;

    cdad_in_if  req_ch ();
    cdad_out_if rsp_ch ();

    calendar_date_add_days #(
        .YEAR_MAX   (YEAR_MAX),
        .MAX_OFFSET (MAX_OFFSET)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    cdad_checker #(
        .YEAR_MAX   (YEAR_MAX),
        .MAX_OFFSET (MAX_OFFSET)
    ) date_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Offer one request transaction after a random gap, hold until taken
    task automatic offer_date(input int y, input int m, input int d, input int off);
        int gap;
        if (sent % 32 == 0)
            send_calm = ($urandom_range(0, 3) == 0);
        gap = send_calm ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.start_year  <= YEAR_IN_W'(y);
        req_ch.start_month <= MONTH_W'(m);
        req_ch.start_day   <= DAY_IN_W'(d);
        req_ch.offset_days <= OFF_IN_W'(off);
        do
            @(posedge clk);
        while (!req_ch.ready);
        sent = sent + 1;
    endtask

    // Mostly legal dates with modest offsets; some full-range noise
    task automatic offer_random_date();
        int y;
        int m;
        int d;
        int off;
        int pick;
        y = ($urandom_range(0, 99) < 85) ? $urandom_range(0, YEAR_MAX)
                                         : $urandom_range(0, 16383);
        m = ($urandom_range(0, 9) != 0) ? $urandom_range(1, 12) : $urandom_range(0, 15);
        d = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 28) : $urandom_range(0, 31);
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            off = int'($urandom_range(0, 800)) - 400;
        end
        else if (pick < 80) begin
            off = int'($urandom_range(0, 10000)) - 5000;
        end
        else if (pick < 85) begin
            // aim below year zero
            y   = $urandom_range(0, 179);
            off = -int'($urandom_range(0, MAX_OFFSET));
        end
        else if (pick < 90) begin
            // aim past the top year
            y   = YEAR_MAX - $urandom_range(0, 179);
            off = int'($urandom_range(0, MAX_OFFSET));
        end
        else begin
            // raw 17-bit pattern, includes the saturating value
            off = $urandom_range(0, 131071);
        end
        offer_date(y, m, d, off);
    endtask

    // Stimulus and verdict
    initial begin
        sent      = 0;
        send_calm = 1'b0;
        rst_n              <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.start_year  <= '0;
        req_ch.start_month <= '0;
        req_ch.start_day   <= '0;
        req_ch.offset_days <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // leap rule: every 400, not every 100, every 4
        offer_date(2000, 2, 29, 0);
        offer_date(1900, 2, 29, 0);
        offer_date(2024, 2, 29, 1);
        offer_date(2023, 2, 29, 0);
        offer_date(100, 1, 31, 29);
        // illegal month and day
        offer_date(2023, 4, 31, 5);
        offer_date(2023, 0, 10, 5);
        offer_date(2023, 13, 10, 5);
        offer_date(2023, 15, 31, -5);
        offer_date(2023, 6, 0, 5);
        // year zero and the top year
        offer_date(0, 1, 1, -1);
        offer_date(0, 1, 1, 0);
        offer_date(0, 3, 1, -1);
        offer_date(YEAR_MAX, 12, 31, 1);
        offer_date(YEAR_MAX, 12, 31, 0);
        // start year past the top year
        offer_date(16383, 12, 31, 0);
        offer_date(10100, 6, 15, -MAX_OFFSET);
        // full offsets, including the one that saturates
        offer_date(2000, 1, 1, MAX_OFFSET);
        offer_date(2000, 1, 1, -MAX_OFFSET);
        offer_date(2000, 1, 1, -65536);
        offer_date(100, 1, 1, -MAX_OFFSET);
        // year carry and borrow across month ends
        offer_date(1999, 12, 31, 1);
        offer_date(2001, 3, 1, -1);
        offer_date(5000, 7, 15, 1);

        repeat (NUM_RANDOM) offer_random_date();
        req_ch.valid <= 1'b0;

        // Drain outstanding results, then watch for strays
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Response side: random gaps, one long hold to back up the block
    initial begin
        int  gap;
        int  taken;
        bit  calm;
        taken = 0;
        calm  = 1'b0;
        rsp_ch.ready <= 1'b0;
        while (!rst_n) @(posedge clk);
        forever begin
            if (taken % 32 == 0)
                calm = ($urandom_range(0, 3) == 0);
            gap = calm ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_ch.valid);
            taken = taken + 1;
            if (taken == HOLD_AT) begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet = 0;
            else
                quiet = quiet + 1;
        end
        $display("CHECK FAILED");
        $finish;
    end

endmodule

### calendar_date_add_days.f
src/cdad_pkg.sv
src/cdad_if.sv
src/cdad_seq.sv
src/calendar_date_add_days.sv
tb/cdad_checker.sv
tb/tb_top.sv
